// ===== design/hevcnal_pkg.sv =====
// ----------------------------------------------------------------------------
// hevcnal_pkg: shared types and constants of the Annex B NAL splitter
// NAL type codes, role and parameter-set status codes, result record and
// the width of the result bus.
// ----------------------------------------------------------------------------
package hevcnal_pkg;

  // default width of the byte position counter
  localparam int OFFSET_BITS_DEF = 24;

  // widths of the result fields
  localparam int TYPE_W  = 6;
  localparam int FIELD_W = 24;
  localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

  // nal unit type codes
  localparam logic [TYPE_W-1:0] TYPE_IDR_W_RADL = 6'd19;
  localparam logic [TYPE_W-1:0] TYPE_IDR_N_LP   = 6'd20;
  localparam logic [TYPE_W-1:0] TYPE_VPS        = 6'd32;
  localparam logic [TYPE_W-1:0] TYPE_SPS        = 6'd33;

  // position role of a unit in the parameter-set run
  localparam logic [1:0] ROLE_OTHER = 2'd0;
  localparam logic [1:0] ROLE_VPS   = 2'd1;
  localparam logic [1:0] ROLE_SPS   = 2'd2;
  localparam logic [1:0] ROLE_PPS   = 2'd3;

  // parameter sets found in the buffer
  localparam logic [1:0] PARAMS_NONE    = 2'd0;
  localparam logic [1:0] PARAMS_SPS_PPS = 2'd1;
  localparam logic [1:0] PARAMS_ALL     = 2'd2;

  // unit index values of interest (index saturates at 7)
  localparam logic [2:0] IDX_FIRST     = 3'd0;
  localparam logic [2:0] IDX_AFTER_SPS = 3'd2;
  localparam logic [2:0] IDX_AFTER_PPS = 3'd3;
  localparam logic [2:0] IDX_MAX       = 3'd7;

  // zero run values
  localparam logic [1:0] ZRUN_TWO   = 2'd2;
  localparam logic [1:0] ZRUN_THREE = 2'd3;

  // start code terminator byte and zero byte
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // one result record
  typedef struct packed {
    logic               nal_valid;
    logic [TYPE_W-1:0]  nal_type;
    logic [FIELD_W-1:0] nal_start;
    logic [FIELD_W-1:0] nal_length;
    logic [1:0]         nal_role;
    logic               is_idr;
    logic               end_of_buffer;
    logic [TYPE_W-1:0]  access_type;
    logic [1:0]         params_found;
  } hevcnal_result_t;

  // result bus data width: 65 payload bits padded to whole bytes
  localparam int OUT_DATA_BITS = TYPE_W + 2 * FIELD_W + 2 + 1 + TYPE_W + 2;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

endpackage

// ===== design/hevcnal_scan.sv =====
// ----------------------------------------------------------------------------
// hevcnal_scan: start code scanner and unit bookkeeping
// Holds the scan state and works out, for the byte at its input, the result
// record and whether a result is produced; state moves on when step is high.
// ----------------------------------------------------------------------------
module hevcnal_scan #(
  parameter int OFFSET_BITS = hevcnal_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  output logic                         emit,
  output hevcnal_pkg::hevcnal_result_t result
);
  import hevcnal_pkg::*;

  localparam int LW = OFFSET_BITS + 1;
  localparam int WW = (LW > FIELD_W + 1) ? LW : FIELD_W + 1;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  // scan state
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [1:0]             zero_run, zero_run_next;
  logic                   unit_open, unit_open_next;
  logic                   header_pending, header_pending_next;
  logic [TYPE_W-1:0]      current_type, current_type_next;
  logic [OFFSET_BITS-1:0] current_start, current_start_next;
  logic [2:0]             unit_index, unit_index_next;
  logic [TYPE_W-1:0]      first_type, first_type_next;
  logic [TYPE_W-1:0]      reported_type, reported_type_next;
  logic [1:0]             param_status, param_status_next;

  // datapath terms
  logic [TYPE_W-1:0]      hdr_type;
  logic                   start_code;
  logic [OFFSET_BITS-1:0] pos_sat;
  logic [OFFSET_BITS-1:0] end_pos;
  logic [OFFSET_BITS-1:0] len_mid;
  logic [LW-1:0]          pos_inc;
  logic [LW-1:0]          len_last;
  logic [LW-1:0]          len_sel;
  logic [WW-1:0]          len_wide;
  logic [WW-1:0]          start_wide;
  logic [1:0]             role;

  assign hdr_type   = data_byte[TYPE_W:1];
  assign start_code = !last_byte && (zero_run >= ZRUN_TWO) && (data_byte == BYTE_ONE);
  assign pos_sat    = (byte_offset == OFF_MAX) ? byte_offset : byte_offset + 1'b1;
  assign pos_inc    = {1'b0, byte_offset} + 1'b1;
  assign end_pos    = (byte_offset >= OFFSET_BITS'(2)) ? byte_offset - OFFSET_BITS'(2)
                                                        : '0;

  // length of a unit closed by the next start code
  always_comb begin
    len_mid = (end_pos > current_start) ? end_pos - current_start : '0;
    if ((zero_run == ZRUN_THREE) && (len_mid != '0)) begin
      len_mid = len_mid - 1'b1;
    end
  end

  // length of a unit closed by the end of the buffer
  assign len_last = (pos_inc > {1'b0, current_start}) ? pos_inc - {1'b0, current_start}
                                                      : '0;

  // header byte handling
  always_comb begin
    current_type_next  = current_type;
    header_pending_next = header_pending;
    first_type_next    = first_type;
    reported_type_next = reported_type;
    param_status_next  = param_status;
    if (header_pending) begin
      current_type_next   = hdr_type;
      header_pending_next = 1'b0;
      if (unit_index == IDX_FIRST) begin
        first_type_next    = hdr_type;
        reported_type_next = hdr_type;
      end else if (first_type == TYPE_VPS && unit_index == IDX_AFTER_PPS) begin
        reported_type_next = hdr_type;
        param_status_next  = PARAMS_ALL;
      end else if (first_type == TYPE_SPS && unit_index == IDX_AFTER_SPS) begin
        reported_type_next = hdr_type;
        param_status_next  = PARAMS_SPS_PPS;
      end
    end
    if (start_code) begin
      header_pending_next = 1'b1;
    end
  end

  // role of the open unit by its position
  always_comb begin
    role = ROLE_OTHER;
    if (first_type_next == TYPE_VPS && unit_index <= 3'd2) begin
      role = 2'(unit_index + 3'd1);
    end else if (first_type_next == TYPE_SPS && unit_index <= 3'd1) begin
      role = 2'(unit_index + 3'd2);
    end
  end

  // unit and position bookkeeping
  always_comb begin
    unit_open_next     = unit_open;
    current_start_next = current_start;
    unit_index_next    = unit_index;
    if (start_code) begin
      unit_open_next     = 1'b1;
      current_start_next = pos_sat;
      if (unit_open && unit_index != IDX_MAX) begin
        unit_index_next = unit_index + 3'd1;
      end
    end
    if (data_byte == BYTE_ZERO) begin
      zero_run_next = (zero_run == ZRUN_THREE) ? zero_run : zero_run + 2'd1;
    end else begin
      zero_run_next = '0;
    end
    byte_offset_next = pos_sat;
  end

  // result record
  assign len_sel    = last_byte ? len_last : {1'b0, len_mid};
  assign len_wide   = WW'(len_sel);
  assign start_wide = WW'(current_start);
  assign emit       = last_byte || (start_code && unit_open);

  always_comb begin
    result.nal_valid     = unit_open;
    result.nal_type      = current_type_next;
    result.nal_start     = start_wide[FIELD_W-1:0];
    result.nal_length    = (len_wide > WW'(FIELD_MAX)) ? FIELD_MAX
                                                        : len_wide[FIELD_W-1:0];
    result.nal_role      = role;
    result.is_idr        = (current_type_next == TYPE_IDR_W_RADL) ||
                           (current_type_next == TYPE_IDR_N_LP);
    result.end_of_buffer = last_byte;
    result.access_type   = reported_type_next;
    result.params_found  = param_status_next;
    if (!unit_open) begin
      result.nal_type   = '0;
      result.nal_start  = '0;
      result.nal_length = '0;
      result.nal_role   = ROLE_OTHER;
      result.is_idr     = 1'b0;
    end
  end

  // state registers; the last byte of a buffer returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_offset    <= '0;
      zero_run       <= '0;
      unit_open      <= 1'b0;
      header_pending <= 1'b0;
      current_type   <= '0;
      current_start  <= '0;
      unit_index     <= '0;
      first_type     <= '0;
      reported_type  <= '0;
      param_status   <= PARAMS_NONE;
    end else if (step) begin
      byte_offset    <= byte_offset_next;
      zero_run       <= zero_run_next;
      unit_open      <= unit_open_next;
      header_pending <= header_pending_next;
      current_type   <= current_type_next;
      current_start  <= current_start_next;
      unit_index     <= unit_index_next;
      first_type     <= first_type_next;
      reported_type  <= reported_type_next;
      param_status   <= param_status_next;
    end
  end

endmodule

// ===== design/hevc_annexb_nal_splitter.sv =====
// ----------------------------------------------------------------------------
// hevc_annexb_nal_splitter: H.265 Annex B start code NAL unit splitter
// Scans an Annex B byte stream and reports each NAL unit it closes.
// ----------------------------------------------------------------------------
// The block takes one byte per clock as long as results are taken: a byte is
// held in the input register, is scanned in a single pass and its result, if
// any, lands in the output register; a byte waits in the input register while
// its result finds the output full and not taken. A result is
// produced when a 00 00 01 start code closes an open unit and on every byte
// marked tlast, which closes the buffer (tlast on the result, tuser low if no
// unit was open) and returns the scanner to its reset state. Unit lengths
// exclude the start code and one zero before it; positions count from the
// first byte of the buffer and saturate at 2^OFFSET_BITS - 1.
module hevc_annexb_nal_splitter #(
  parameter int OFFSET_BITS = hevcnal_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input bytes
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // [7:0] data_byte
  input  logic                               s_tlast,  // last_byte
  // unit reports
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [5:0] nal_type, [29:6] nal_start, [53:30] nal_length, [55:54] nal_role,
  // [56] is_idr, [62:57] access_type, [64:63] params_found, rest zero
  output logic [hevcnal_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                               m_tuser,  // nal_valid
  output logic                               m_tlast   // end_of_buffer
);
  import hevcnal_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // output register
  logic            out_valid;
  hevcnal_result_t out_res;

  // scan stage
  logic            emit;
  logic            advance;
  hevcnal_result_t scan_res;

  // an item leaves the input register unless its result finds the output full and not taken
  assign advance  = in_valid && (!emit || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  hevcnal_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .emit      (emit),
    .result    (scan_res)
  );

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res <= scan_res;
    end
  end

  // result transfer packing
  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.nal_valid;
  assign m_tlast  = out_res.end_of_buffer;
  assign m_tdata  = OUT_DATA_W'({out_res.params_found, out_res.access_type,
                                 out_res.is_idr, out_res.nal_role,
                                 out_res.nal_length, out_res.nal_start,
                                 out_res.nal_type});

`ifndef SYNTHESIS
  // a result without a unit only comes from the end of the buffer
  a_empty_is_eob: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("empty result without end of buffer");

  // idr flag agrees with the reported type
  a_idr_type: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[56] |-> (m_tdata[5:0] == TYPE_IDR_W_RADL ||
                                 m_tdata[5:0] == TYPE_IDR_N_LP))
    else $error("idr flag on a non-idr type");

  // a role is only given to a real unit
  a_role_unit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[55:54] != ROLE_OTHER) |-> m_tuser)
    else $error("role reported without a unit");

  // a waiting result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |-> !(advance && emit))
    else $error("result register overwritten while stalled");
`endif

endmodule
